// ===== rtl/wpvf_pkg.sv =====
// package for the windowed peak voltage filter
// holds register indexes, reset values, counter widths and the config struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wpvf_pkg;

	// sample width default, legal range 8 to 32
	localparam int SAMPLE_BITS_DEF = 16;

	// configuration register width and index width
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 8;

	// window counter and repeat counter width
	localparam int COUNT_W = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAJORITY_HITS = CFG_IDX_W'(1);

	// reset values: window of 3000 ms at 5 ms per sample, a fifth of it as majority
	localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = CFG_W'(3000 / 5);
	localparam logic [CFG_W-1:0] MAJORITY_HITS_RST = CFG_W'(600 / 5);

	// configuration as seen by the tracker
	typedef struct packed {
		logic [CFG_W-1:0] window_length;
		logic [CFG_W-1:0] majority_hits;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/wpvf_track.sv =====
// window tracker: peak, displaced peak, repeat count and held result
// computes the filtered voltage for the accepted sample; uses wpvf_pkg
`timescale 1ns / 1ps
`default_nettype none

module wpvf_track #(
	parameter int SAMPLE_BITS = wpvf_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire wpvf_pkg::cfg_t         cfg,
	input  wire logic                   accept,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	output logic      [SAMPLE_BITS-1:0] result
);
	import wpvf_pkg::*;

	logic [COUNT_W-1:0]     count_q;
	logic [COUNT_W-1:0]     repeats_q;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic [SAMPLE_BITS-1:0] runner_q;
	logic [SAMPLE_BITS-1:0] held_q;

	logic                   decide;
	logic [SAMPLE_BITS-1:0] held_d;

	// the sample after a full window settles the held result
	assign decide = (count_q >= cfg.window_length);

	always_comb begin
		held_d = held_q;
		if (decide) begin
			if (repeats_q >= cfg.majority_hits) begin
				held_d = peak_q;
			end else if (runner_q != '0) begin
				held_d = runner_q;
			end
		end
	end

	// pass the sample through while nothing is held
	assign result = (held_d != '0) ? held_d : sample;

	// tracking state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			repeats_q <= '0;
			peak_q    <= '0;
			runner_q  <= '0;
			held_q    <= '0;
		end else if (accept) begin
			held_q <= held_d;
			if (decide) begin
				count_q   <= '0;
				repeats_q <= '0;
				peak_q    <= '0;
				runner_q  <= '0;
			end else begin
				count_q <= count_q + COUNT_W'(1);
				if (peak_q < sample) begin
					runner_q  <= peak_q;
					peak_q    <= sample;
					repeats_q <= '0;
				end else if (peak_q == sample) begin
					if (repeats_q != COUNT_MAX) begin
						repeats_q <= repeats_q + COUNT_W'(1);
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	// displaced peak stays below the peak unless both are cleared
	a_runner_below_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(runner_q < peak_q) || ((runner_q == '0) && (peak_q == '0)))
		else $error("displaced peak not below peak");

	// a decision starts a fresh window
	a_decide_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && decide) |=> ((count_q == '0) && (peak_q == '0) && (repeats_q == '0)))
		else $error("window not cleared after decision");

	// a higher tracked sample becomes the peak with no repeats
	a_new_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !decide && (peak_q < sample)) |=>
		((peak_q == $past(sample)) && (repeats_q == '0)))
		else $error("new peak not taken");
`endif

endmodule

`default_nettype wire

// ===== rtl/windowed_peak_voltage_filter.sv =====
// top level of the windowed peak voltage filter
// config registers, stream handshake and result register; uses wpvf_pkg, wpvf_track
//
// channel  | direction | word
// s_*      | in        | tdata: sample [SAMPLE_BITS-1:0]
// m_*      | out       | tdata: filtered_voltage [SAMPLE_BITS-1:0]
// cfg_*    | in        | cfg_index: register index, cfg_data: register value
//
// one sample per cycle while s_tready is high; each sample gives one word in the next cycle
// the single result register holds each word; tracking state updates as the sample is taken
// s_tready is high while the result register is empty or being taken
// arst_n clears tracking state, config to 600 / 120 and the result valid flag
// cfg_ready is always high; writes to unknown indexes are dropped
`timescale 1ns / 1ps
`default_nettype none

module windowed_peak_voltage_filter #(
	parameter int SAMPLE_BITS = wpvf_pkg::SAMPLE_BITS_DEF,
	localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [TDATA_W-1:0]             s_tdata,   // sample
	// output stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [TDATA_W-1:0]             m_tdata,   // filtered_voltage
	// configuration write
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [wpvf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wpvf_pkg::CFG_W-1:0]     cfg_data
);
	import wpvf_pkg::*;

	cfg_t                   cfg_q;
	logic                   accept;
	logic [SAMPLE_BITS-1:0] result;
	logic [SAMPLE_BITS-1:0] result_q;
	logic                   valid_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length <= WINDOW_LENGTH_RST;
			cfg_q.majority_hits <= MAJORITY_HITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: cfg_q.window_length <= cfg_data;
				REG_MAJORITY_HITS: cfg_q.majority_hits <= cfg_data;
				default: ;
			endcase
		end
	end

	wpvf_track #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.sample (s_tdata[SAMPLE_BITS-1:0]),
		.result (result)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = TDATA_W'(result_q);

`ifndef SYNTHESIS
	// every taken sample shows up as a word in the next cycle
	a_accept_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("taken sample produced no word");

	// a taken word with no new sample empties the result register
	a_word_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !s_tvalid) |=> !m_tvalid)
		else $error("word repeated");

	// a new word carries the tracker result of its sample
	a_word_value: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (m_tdata[SAMPLE_BITS-1:0] == $past(result)))
		else $error("word differs from tracker result");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/wpvf_monitor.sv =====
// checker for the windowed peak voltage filter: watches the sample, result and register channels
// predicts each filtered word from its own copy of the tracking state; uses wpvf_pkg
`timescale 1ns / 1ps
`default_nettype none

module wpvf_monitor #(
	parameter int SAMPLE_W = 16,
	parameter int DATA_W   = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [DATA_W-1:0]              s_tdata,   // sample
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [DATA_W-1:0]              m_tdata,   // filtered_voltage
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [wpvf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wpvf_pkg::CFG_W-1:0]     cfg_data,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  words_checked
);
	import wpvf_pkg::*;

	// register copies
	logic [CFG_W-1:0] window_len  = WINDOW_LENGTH_RST;
	logic [CFG_W-1:0] hits_needed = MAJORITY_HITS_RST;

	// tracking state
	logic [COUNT_W-1:0]  taken     = '0;
	logic [COUNT_W-1:0]  repeats   = '0;
	logic [SAMPLE_W-1:0] peak      = '0;
	logic [SAMPLE_W-1:0] displaced = '0;
	logic [SAMPLE_W-1:0] held      = '0;

	// words still owed by the filter, oldest first
	logic [SAMPLE_W-1:0] expected_voltage[$];

	int failures = 0;
	int checked  = 0;
	int owed     = 0;

	assign fail_count    = failures;
	assign pending       = owed;
	assign words_checked = checked;

	task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
			input logic [SAMPLE_W-1:0] want);
		failures++;
		$display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	// one sample through the window tracker, gives the filtered word
	task automatic filter_step(input logic [SAMPLE_W-1:0] s, output logic [SAMPLE_W-1:0] v);
		if (taken < window_len) begin
			taken = taken + 1'b1;
			if (peak < s) begin
				displaced = peak;
				peak      = s;
				repeats   = '0;
			end else if (peak == s && repeats != COUNT_MAX) begin
				repeats = repeats + 1'b1;
			end
		end else begin
			// decision sample
			if (repeats >= hits_needed)
				held = peak;
			else if (displaced != '0)
				held = displaced;
			peak      = '0;
			displaced = '0;
			repeats   = '0;
			taken     = '0;
		end
		v = (held != '0) ? held : s;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic [SAMPLE_W-1:0] want;
		logic [SAMPLE_W-1:0] next_word;
		if (!arst_n) begin
			window_len  = WINDOW_LENGTH_RST;
			hits_needed = MAJORITY_HITS_RST;
			taken       = '0;
			repeats     = '0;
			peak        = '0;
			displaced   = '0;
			held        = '0;
			expected_voltage.delete();
			owed        = 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_LENGTH: window_len  = cfg_data;
					REG_MAJORITY_HITS: hits_needed = cfg_data;
					default: ;
				endcase
			end
			// outgoing word against the oldest prediction
			if (m_tvalid && m_tready) begin
				checked++;
				if (expected_voltage.size() == 0) begin
					report_mismatch("word with nothing pending", m_tdata[SAMPLE_W-1:0], 'x);
				end else begin
					want = expected_voltage.pop_front();
					if (m_tdata[SAMPLE_W-1:0] !== want)
						report_mismatch("filtered_voltage", m_tdata[SAMPLE_W-1:0], want);
				end
			end
			// incoming sample
			if (s_tvalid && s_tready) begin
				filter_step(s_tdata[SAMPLE_W-1:0], next_word);
				expected_voltage.push_back(next_word);
			end
			owed = expected_voltage.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/windowed_peak_voltage_filter_test.sv =====
// testbench top for the windowed peak voltage filter: clock, reset, samples and register writes
// directed cases, a long window of zeros, then random phases; uses wpvf_pkg, wpvf_monitor
`timescale 1ns / 1ps
`default_nettype none

module windowed_peak_voltage_filter_test;
	import wpvf_pkg::*;

	localparam int SAMPLE_W    = 16;
	localparam int DATA_W      = ((SAMPLE_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES      = 17;
	localparam int PHASE_ITEMS = 44;
	localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = REG_MAJORITY_HITS + 1'b1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [DATA_W-1:0]    s_tdata  = '0;   // sample
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [DATA_W-1:0]    m_tdata;         // filtered_voltage
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	int fail_count;
	int pending;
	int words_checked;
	int samples_sent = 0;
	int reg_writes   = 0;
	int cycles       = 0;

	// no idling on either side while set
	bit steady = 1'b0;

	windowed_peak_voltage_filter #(.SAMPLE_BITS(SAMPLE_W)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	wpvf_monitor #(.SAMPLE_W(SAMPLE_W), .DATA_W(DATA_W)) i_monitor (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .words_checked(words_checked)
	);

	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// idle cycles before the next word on either side
	function automatic int pick_gap();
		if (steady || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// result side: random stalls
	initial begin : drain
		int stall;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// one sample word, entered and left at a falling edge
	task automatic send_sample(input logic [SAMPLE_W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= DATA_W'(v);
		do @(posedge clk); while (!s_tready);
		samples_sent++;
		@(negedge clk);
	endtask

	// hold samples until every word has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [SAMPLE_W-1:0] pool [4];
		logic [SAMPLE_W-1:0] last;
		logic [SAMPLE_W-1:0] s;
		int pick;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: extremes pass through while nothing is held
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		// window cut below what is already tracked: next sample decides
		write_reg(REG_WINDOW_LENGTH, 16'd2);
		send_sample(16'h1234);
		// runner-up kept by a sample between it and the peak, then peak majority
		write_reg(REG_MAJORITY_HITS, 16'd1);
		write_reg(REG_WINDOW_LENGTH, 16'd3);
		send_sample(16'd100);
		send_sample(16'd200);
		send_sample(16'd150);
		send_sample(16'd7);
		send_sample(16'd300);
		send_sample(16'd300);
		send_sample(16'd200);
		send_sample(16'd9);
		// zero window and zero majority: every sample decides and holds zero
		write_reg(REG_MAJORITY_HITS, 16'd0);
		write_reg(REG_WINDOW_LENGTH, 16'd0);
		send_sample(16'd5);
		send_sample(16'd0);
		// one-sample window
		write_reg(REG_WINDOW_LENGTH, 16'd1);
		send_sample(16'hFFFF);
		send_sample(16'd1);
		send_sample(16'd2);
		send_sample(16'd3);

		// long window of zeros: enough repeats to hold zero, then pass-through
		steady = 1'b1;
		write_reg(REG_WINDOW_LENGTH, 16'd64);
		write_reg(REG_MAJORITY_HITS, 16'd60);
		repeat (65) send_sample(16'h0000);
		send_sample(16'h4321);
		steady = 1'b0;

		// random phases: small windows, pools of repeating values, some noise
		for (int phase = 0; phase < PHASES; phase++) begin
			steady = (phase % 4 == 3);
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, 255)), CFG_W'($urandom));
			case ($urandom_range(0, 5))
				0: write_reg(REG_MAJORITY_HITS, 16'd0);
				1: write_reg(REG_MAJORITY_HITS, 16'hFFFF);
				default: write_reg(REG_MAJORITY_HITS, CFG_W'($urandom_range(1, 4)));
			endcase
			if ($urandom_range(0, 4) == 0)
				write_reg(REG_WINDOW_LENGTH, CFG_W'($urandom_range(13, 60)));
			else
				write_reg(REG_WINDOW_LENGTH, CFG_W'($urandom_range(0, 12)));
			pool[0] = SAMPLE_W'($urandom);
			pool[1] = pool[0] + 1'b1;
			pool[2] = SAMPLE_W'($urandom_range(0, 255));
			pool[3] = 16'hFFFF - SAMPLE_W'($urandom_range(0, 3));
			last    = pool[2];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 9);
				if (pick < 5)
					s = pool[$urandom_range(0, 3)];
				else if (pick < 7)
					s = last + SAMPLE_W'($urandom_range(1, 64));
				else if (pick == 7)
					s = '0;
				else
					s = SAMPLE_W'($urandom);
				last = s;
				send_sample(s);
			end
		end

		wait_drained();
		repeat (5) @(negedge clk);
		$display("covered %0d samples and %0d register writes, %0d words compared",
			samples_sent, reg_writes, words_checked);
		$display("windows from zero to 64 samples, majority from zero to full scale");
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
